[design/lens_actuator_ramp_controller_core_assert.svh]
// Assertion macros for the lens actuator ramp controller.
// Used by lens_actuator_ramp_controller_core.sv; no other dependencies.
`ifndef LENS_ACTUATOR_RAMP_CONTROLLER_CORE_ASSERT_SVH
`define LENS_ACTUATOR_RAMP_CONTROLLER_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
`define ASSERT_CLK(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ASSERT_NEVER(name, clk, rst_n, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_CLK(name, clk, rst_n, prop)
`define ASSERT_NEVER(name, clk, rst_n, expr)
`endif

`endif

[design/larc_pkg.sv]
// Package for the lens actuator ramp controller: widths, reset values, codes.
// No dependencies.
package larc_pkg;

    localparam int POSITION_BITS   = 10;
    localparam int USER_COUNT_BITS = 8;
    localparam int POLL_BITS       = 8;
    localparam int CFG_DATA_BITS   = POSITION_BITS;
    localparam int CFG_INDEX_BITS  = 2;

    localparam logic [POSITION_BITS-1:0]   RAMP_STEP_RESET   = POSITION_BITS'(16);
    localparam logic [POSITION_BITS-1:0]   IDLE_POS_RESET    = POSITION_BITS'(512);
    localparam logic [POLL_BITS-1:0]       RETRY_LIMIT_RESET = POLL_BITS'(10);
    localparam logic [POSITION_BITS-1:0]   START_POS_RESET   = POSITION_BITS'(480);
    localparam logic [USER_COUNT_BITS-1:0] USERS_MAX         = '1;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_RAMP_STEP   = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_IDLE_POS    = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_RETRY_LIMIT = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_START_POS   = 2'd3;

    typedef enum logic [1:0] {
        MODE_SET  = 2'd0,
        MODE_UP   = 2'd1,
        MODE_DOWN = 2'd2,
        MODE_TICK = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_WAKE  = 2'd1,
        KIND_SLEEP = 2'd2,
        KIND_MOVE  = 2'd3
    } t_ramp_kind;

    typedef enum logic [2:0] {
        ERR_OK        = 3'd0,
        ERR_BUSY      = 3'd1,
        ERR_LINK      = 3'd2,
        ERR_UNMATCHED = 3'd3,
        ERR_REJECT    = 3'd4
    } t_err;

endpackage

[design/lens_actuator_ramp_controller_core.sv]
// Lens actuator ramp controller: event-driven slew-limited DAC positioner.
// Depends on larc_pkg.sv and lens_actuator_ramp_controller_core_assert.svh.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one event per beat:
//   set target, power up, power down or tick, with busy and link status.
//   Output channel (o_out_valid / i_out_stall) returns exactly one result
//   beat per event: DAC write, control write, ramp done, error, powered.
//   The event updates the state and loads the result register at the
//   accepting edge. Throughput is one event per cycle; the next event is
//   taken while a result waits, as long as the result register is empty
//   or being drained in the same cycle.
//   o_in_stall rises only when a result is held and i_out_stall is high;
//   the held result stays unchanged until taken.
//   Reset (i_rst_n low, synchronous) loads the configuration defaults,
//   clears the user count and any ramp, and empties the result register.
//   The user must make configuration writes (i_cfg_we) only while the
//   block is idle; the block does not enforce it. The start position only
//   matters at reset, where its default is used; writes have no effect.
module lens_actuator_ramp_controller_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [larc_pkg::CFG_INDEX_BITS-1:0]   i_cfg_index,
    input  logic [larc_pkg::CFG_DATA_BITS-1:0]    i_cfg_data,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [1:0]                            i_mode,
    input  logic [larc_pkg::POSITION_BITS-1:0]    i_target_position,
    input  logic                                  i_actuator_busy,
    input  logic                                  i_link_error,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic                                  o_dac_write,
    output logic [larc_pkg::POSITION_BITS-1:0]    o_dac_value,
    output logic                                  o_control_write,
    output logic                                  o_standby,
    output logic                                  o_ramp_done,
    output logic [2:0]                            o_error_code,
    output logic                                  o_powered
);

    localparam int PB = larc_pkg::POSITION_BITS;
    localparam int UB = larc_pkg::USER_COUNT_BITS;
    localparam int CB = larc_pkg::POLL_BITS;

    // configuration
    logic [PB-1:0] r_ramp_step;
    logic [PB-1:0] r_idle_pos;
    logic [CB-1:0] r_retry_limit;

    // controller state
    logic [PB-1:0]           r_committed, n_committed;
    logic [PB-1:0]           r_rollback,  n_rollback;
    logic [PB-1:0]           r_ramp_pos,  n_ramp_pos;
    logic [PB-1:0]           r_ramp_tgt,  n_ramp_tgt;
    larc_pkg::t_ramp_kind    r_kind,      n_kind;
    logic [UB-1:0]           r_users,     n_users;
    logic [CB-1:0]           r_polls,     n_polls;

    // result register
    logic               r_out_valid;
    logic               r_dac_write,  n_dac_write;
    logic [PB-1:0]      r_dac_value,  n_dac_value;
    logic               r_ctrl_write, n_ctrl_write;
    logic               r_standby,    n_standby;
    logic               r_done,       n_done;
    larc_pkg::t_err     r_err,        n_err;
    logic               r_powered;

    logic               in_accept;
    logic               ramping;
    logic               do_abort;
    larc_pkg::t_mode    mode;
    logic [PB-1:0]      step;
    logic [PB:0]        sum_up;
    logic [PB:0]        sum_tgt;
    logic [PB-1:0]      up_next;
    logic [PB-1:0]      dn_next;
    logic [PB-1:0]      next_pos;
    logic [CB-1:0]      polls_inc;

    logic               user_ramp;
    logic               out_err;
    logic               sleep_end;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_accept  = i_in_valid && !o_in_stall;
    assign mode       = larc_pkg::t_mode'(i_mode);
    assign ramping    = (r_kind != larc_pkg::KIND_NONE);

    // one ramp step toward the target, clamped onto it
    assign step     = (r_ramp_step == '0) ? PB'(1) : r_ramp_step;
    assign sum_up   = {1'b0, r_ramp_pos} + {1'b0, step};
    assign sum_tgt  = {1'b0, r_ramp_tgt} + {1'b0, step};
    assign up_next  = (sum_up >= {1'b0, r_ramp_tgt}) ? r_ramp_tgt : sum_up[PB-1:0];
    assign dn_next  = ({1'b0, r_ramp_pos} <= sum_tgt) ? r_ramp_tgt : r_ramp_pos - step;
    assign next_pos = (r_ramp_pos < r_ramp_tgt) ? up_next : dn_next;
    assign polls_inc = r_polls + CB'(1);

    always_comb begin
        n_committed  = r_committed;
        n_rollback   = r_rollback;
        n_ramp_pos   = r_ramp_pos;
        n_ramp_tgt   = r_ramp_tgt;
        n_kind       = r_kind;
        n_users      = r_users;
        n_polls      = r_polls;
        n_dac_write  = 1'b0;
        n_dac_value  = '0;
        n_ctrl_write = 1'b0;
        n_standby    = 1'b0;
        n_done       = 1'b0;
        n_err        = larc_pkg::ERR_OK;
        do_abort     = 1'b0;

        if (mode != larc_pkg::MODE_TICK && ramping) begin
            n_err = larc_pkg::ERR_REJECT;
        end else begin
            case (mode)
                larc_pkg::MODE_SET: begin
                    n_committed = i_target_position;
                    if (r_users != '0) begin
                        n_rollback = r_committed;
                        n_kind     = larc_pkg::KIND_MOVE;
                        n_ramp_pos = r_committed;
                        n_ramp_tgt = i_target_position;
                        n_polls    = '0;
                    end
                end
                larc_pkg::MODE_UP: begin
                    if (r_users != '0) begin
                        if (r_users != larc_pkg::USERS_MAX) begin
                            n_users = r_users + UB'(1);
                        end
                    end else begin
                        n_users      = UB'(1);
                        n_ctrl_write = 1'b1;
                        n_kind       = larc_pkg::KIND_WAKE;
                        n_ramp_pos   = r_idle_pos;
                        n_ramp_tgt   = r_committed;
                        n_polls      = '0;
                    end
                end
                larc_pkg::MODE_DOWN: begin
                    if (r_users == '0) begin
                        n_err = larc_pkg::ERR_UNMATCHED;
                    end else begin
                        n_users = r_users - UB'(1);
                        if (r_users == UB'(1)) begin
                            n_kind     = larc_pkg::KIND_SLEEP;
                            n_ramp_pos = r_committed;
                            n_ramp_tgt = r_idle_pos;
                            n_polls    = '0;
                        end
                    end
                end
                larc_pkg::MODE_TICK: begin
                    if (ramping) begin
                        if (i_link_error) begin
                            n_err    = larc_pkg::ERR_LINK;
                            do_abort = 1'b1;
                        end else if (i_actuator_busy) begin
                            n_polls = polls_inc;
                            if (polls_inc >= r_retry_limit) begin
                                n_err    = larc_pkg::ERR_BUSY;
                                do_abort = 1'b1;
                            end
                        end else begin
                            n_dac_write = 1'b1;
                            n_dac_value = next_pos;
                            n_ramp_pos  = next_pos;
                            n_polls     = '0;
                            if (next_pos == r_ramp_tgt) begin
                                n_done = 1'b1;
                                if (r_kind == larc_pkg::KIND_SLEEP) begin
                                    n_ctrl_write = 1'b1;
                                    n_standby    = 1'b1;
                                end
                                n_kind = larc_pkg::KIND_NONE;
                            end
                        end
                    end
                end
                default: begin
                    n_err = larc_pkg::ERR_OK;
                end
            endcase
        end

        if (do_abort) begin
            if (r_kind == larc_pkg::KIND_MOVE) begin
                n_committed = r_rollback;
            end else if (r_kind == larc_pkg::KIND_WAKE) begin
                n_users = '0;
            end
            n_kind  = larc_pkg::KIND_NONE;
            n_polls = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ramp_step   <= larc_pkg::RAMP_STEP_RESET;
            r_idle_pos    <= larc_pkg::IDLE_POS_RESET;
            r_retry_limit <= larc_pkg::RETRY_LIMIT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                larc_pkg::CFG_RAMP_STEP:   r_ramp_step   <= i_cfg_data;
                larc_pkg::CFG_IDLE_POS:    r_idle_pos    <= i_cfg_data;
                larc_pkg::CFG_RETRY_LIMIT: r_retry_limit <= i_cfg_data[CB-1:0];
                larc_pkg::CFG_START_POS:   r_retry_limit <= r_retry_limit;
                default:                   r_retry_limit <= r_retry_limit;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_committed <= larc_pkg::START_POS_RESET;
            r_rollback  <= '0;
            r_ramp_pos  <= larc_pkg::IDLE_POS_RESET;
            r_ramp_tgt  <= '0;
            r_kind      <= larc_pkg::KIND_NONE;
            r_users     <= '0;
            r_polls     <= '0;
        end else if (in_accept) begin
            r_committed <= n_committed;
            r_rollback  <= n_rollback;
            r_ramp_pos  <= n_ramp_pos;
            r_ramp_tgt  <= n_ramp_tgt;
            r_kind      <= n_kind;
            r_users     <= n_users;
            r_polls     <= n_polls;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_dac_write  <= n_dac_write;
            r_dac_value  <= n_dac_value;
            r_ctrl_write <= n_ctrl_write;
            r_standby    <= n_standby;
            r_done       <= n_done;
            r_err        <= n_err;
            r_powered    <= (n_users != '0);
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_dac_write     = r_dac_write;
    assign o_dac_value     = r_dac_value;
    assign o_control_write = r_ctrl_write;
    assign o_standby       = r_standby;
    assign o_ramp_done     = r_done;
    assign o_error_code    = r_err;
    assign o_powered       = r_powered;

    assign user_ramp = (r_kind == larc_pkg::KIND_MOVE) || (r_kind == larc_pkg::KIND_WAKE);
    assign out_err   = o_out_valid && (o_error_code != larc_pkg::ERR_OK);
    assign sleep_end = o_control_write && o_ramp_done && o_dac_write && !o_powered;

`include "lens_actuator_ramp_controller_core_assert.svh"

    // move and wake ramps only exist while someone holds power
    `ASSERT_NEVER(a_ramp_needs_user, i_clk, i_rst_n, (r_users == '0) && user_ramp)
    `ASSERT_CLK(a_idle_no_polls, i_clk, i_rst_n, !ramping |-> (r_polls == '0))
    `ASSERT_CLK(a_err_no_write, i_clk, i_rst_n, out_err |-> (!o_dac_write && !o_ramp_done))
    `ASSERT_CLK(a_standby_at_done, i_clk, i_rst_n, (o_out_valid && o_standby) |-> sleep_end)
    `ASSERT_NEVER(a_no_write_zero, i_clk, i_rst_n, o_out_valid && !o_dac_write && (|o_dac_value))

endmodule

[dv/lens_actuator_ramp_controller_core_tb.sv]
`timescale 1ns / 100ps
// Testbench for lens_actuator_ramp_controller_core: directed and random events,
// a ramp positioner predictor and an in-order result scoreboard.
// Depends on larc_pkg.sv and the core RTL.

typedef struct packed {
    larc_pkg::t_mode                    mode;
    logic [larc_pkg::POSITION_BITS-1:0] target;
    logic                               busy;
    logic                               link;
} t_ramp_event;

typedef struct packed {
    logic                               dac_write;
    logic [larc_pkg::POSITION_BITS-1:0] dac_value;
    logic                               control_write;
    logic                               standby;
    logic                               ramp_done;
    logic [2:0]                         error_code;
    logic                               powered;
} t_ramp_result;

class positioner_scoreboard;
    logic [larc_pkg::POSITION_BITS-1:0]   step_size;
    logic [larc_pkg::POSITION_BITS-1:0]   idle_pos;
    logic [larc_pkg::POLL_BITS-1:0]       retry_limit;
    logic [larc_pkg::POSITION_BITS-1:0]   start_pos;
    logic [larc_pkg::POSITION_BITS-1:0]   committed;
    logic [larc_pkg::POSITION_BITS-1:0]   rollback;
    logic [larc_pkg::POSITION_BITS-1:0]   ramp_pos;
    logic [larc_pkg::POSITION_BITS-1:0]   ramp_end;
    larc_pkg::t_ramp_kind                 kind;
    logic [larc_pkg::USER_COUNT_BITS-1:0] users;
    logic [larc_pkg::POLL_BITS-1:0]       polls;
    t_ramp_result                         owed_beats[$];
    int                                   mismatches;

    function new();
        step_size   = larc_pkg::RAMP_STEP_RESET;
        idle_pos    = larc_pkg::IDLE_POS_RESET;
        retry_limit = larc_pkg::RETRY_LIMIT_RESET;
        start_pos   = larc_pkg::START_POS_RESET;
        committed   = larc_pkg::START_POS_RESET;
        rollback    = '0;
        ramp_pos    = larc_pkg::IDLE_POS_RESET;
        ramp_end    = '0;
        kind        = larc_pkg::KIND_NONE;
        users       = '0;
        polls       = '0;
        mismatches  = 0;
    endfunction

    function void write_reg(logic [larc_pkg::CFG_INDEX_BITS-1:0] idx,
                            logic [larc_pkg::CFG_DATA_BITS-1:0] data);
        case (idx)
            larc_pkg::CFG_RAMP_STEP:   step_size = data;
            larc_pkg::CFG_IDLE_POS:    idle_pos = data;
            larc_pkg::CFG_RETRY_LIMIT: retry_limit = data[larc_pkg::POLL_BITS-1:0];
            default:                   start_pos = data;
        endcase
    endfunction

    function void start_ramp(larc_pkg::t_ramp_kind k,
                             logic [larc_pkg::POSITION_BITS-1:0] from,
                             logic [larc_pkg::POSITION_BITS-1:0] to);
        kind     = k;
        ramp_pos = from;
        ramp_end = to;
        polls    = '0;
    endfunction

    function void abort_ramp();
        if (kind == larc_pkg::KIND_MOVE) begin
            committed = rollback;
        end else if (kind == larc_pkg::KIND_WAKE) begin
            users = '0;
        end
        kind  = larc_pkg::KIND_NONE;
        polls = '0;
    endfunction

    // Applies one event to the positioner state and returns its result beat.
    function t_ramp_result advance_positioner(t_ramp_event ev);
        t_ramp_result                       r;
        int                                 step;
        int                                 p;
        int                                 t;
        int                                 np;
        logic [larc_pkg::POSITION_BITS-1:0] prev;
        r    = '0;
        step = (step_size == 0) ? 1 : int'(step_size);
        if (ev.mode != larc_pkg::MODE_TICK && kind != larc_pkg::KIND_NONE) begin
            r.error_code = larc_pkg::ERR_REJECT;
        end else begin
            case (ev.mode)
                larc_pkg::MODE_SET: begin
                    prev      = committed;
                    committed = ev.target;
                    if (users != 0) begin
                        rollback = prev;
                        start_ramp(larc_pkg::KIND_MOVE, prev, ev.target);
                    end
                end
                larc_pkg::MODE_UP: begin
                    if (users == 0) begin
                        users           = larc_pkg::USER_COUNT_BITS'(1);
                        r.control_write = 1'b1;
                        start_ramp(larc_pkg::KIND_WAKE, idle_pos, committed);
                    end else if (users != larc_pkg::USERS_MAX) begin
                        users++;
                    end
                end
                larc_pkg::MODE_DOWN: begin
                    if (users == 0) begin
                        r.error_code = larc_pkg::ERR_UNMATCHED;
                    end else begin
                        users--;
                        if (users == 0) begin
                            start_ramp(larc_pkg::KIND_SLEEP, committed, idle_pos);
                        end
                    end
                end
                default: begin
                    if (kind != larc_pkg::KIND_NONE) begin
                        if (ev.link) begin
                            r.error_code = larc_pkg::ERR_LINK;
                            abort_ramp();
                        end else if (ev.busy) begin
                            polls++;
                            if (polls >= retry_limit) begin
                                r.error_code = larc_pkg::ERR_BUSY;
                                abort_ramp();
                            end
                        end else begin
                            p = int'(ramp_pos);
                            t = int'(ramp_end);
                            if (p < t) begin
                                np = (p + step >= t) ? t : p + step;
                            end else begin
                                np = (p <= t + step) ? t : p - step;
                            end
                            ramp_pos    = larc_pkg::POSITION_BITS'(np);
                            polls       = '0;
                            r.dac_write = 1'b1;
                            r.dac_value = ramp_pos;
                            if (ramp_pos == ramp_end) begin
                                r.ramp_done = 1'b1;
                                if (kind == larc_pkg::KIND_SLEEP) begin
                                    r.control_write = 1'b1;
                                    r.standby       = 1'b1;
                                end
                                kind = larc_pkg::KIND_NONE;
                            end
                        end
                    end
                end
            endcase
        end
        r.powered = (users != 0);
        return r;
    endfunction

    function void note_event(t_ramp_event ev);
        owed_beats.push_back(advance_positioner(ev));
    endfunction

    function void compare_field(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
            mismatches++;
        end
    endfunction

    function void check_result(t_ramp_result got);
        t_ramp_result want;
        if (owed_beats.size() == 0) begin
            $display("%0t: result beat with nothing expected, got %h", $time, got);
            mismatches++;
            return;
        end
        want = owed_beats.pop_front();
        compare_field("dac_write", want.dac_write, got.dac_write);
        compare_field("dac_value", want.dac_value, got.dac_value);
        compare_field("control_write", want.control_write, got.control_write);
        compare_field("standby", want.standby, got.standby);
        compare_field("ramp_done", want.ramp_done, got.ramp_done);
        compare_field("error_code", want.error_code, got.error_code);
        compare_field("powered", want.powered, got.powered);
    endfunction
endclass

module lens_actuator_ramp_controller_core_tb;
    localparam int CYCLE_LIMIT      = 200000;
    localparam int RANDOM_PER_PHASE = 90;
    localparam int POS_TOP          = (1 << larc_pkg::POSITION_BITS) - 1;

    logic                                i_clk;
    logic                                i_rst_n;
    logic                                i_cfg_we;
    logic [larc_pkg::CFG_INDEX_BITS-1:0] i_cfg_index;
    logic [larc_pkg::CFG_DATA_BITS-1:0]  i_cfg_data;
    logic                                i_in_valid;
    logic                                o_in_stall;
    logic [1:0]                          i_mode;
    logic [larc_pkg::POSITION_BITS-1:0]  i_target_position;
    logic                                i_actuator_busy;
    logic                                i_link_error;
    logic                                o_out_valid;
    logic                                i_out_stall;
    logic                                o_dac_write;
    logic [larc_pkg::POSITION_BITS-1:0]  o_dac_value;
    logic                                o_control_write;
    logic                                o_standby;
    logic                                o_ramp_done;
    logic [2:0]                          o_error_code;
    logic                                o_powered;

    positioner_scoreboard positioner = new();
    int send_idle_pct  = 18;
    int recv_stall_pct = 46;
    int cycles         = 0;

    lens_actuator_ramp_controller_core u_dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("[lens_actuator_ramp_controller_core] ERROR");
        $finish;
    end

    // result side: sample at the rising edge, pick the stall at the falling edge
    initial begin
        t_ramp_result seen;
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                seen = '{o_dac_write, o_dac_value, o_control_write, o_standby,
                         o_ramp_done, o_error_code, o_powered};
                positioner.check_result(seen);
            end
            @(negedge i_clk);
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    function automatic t_ramp_event make_event(larc_pkg::t_mode m, int target, bit busy,
                                               bit link);
        t_ramp_event ev;
        ev.mode   = m;
        ev.target = larc_pkg::POSITION_BITS'(target);
        ev.busy   = busy;
        ev.link   = link;
        return ev;
    endfunction

    // Well-formed traffic: mostly ticks while a ramp runs, nearby targets when settled.
    function automatic t_ramp_event pick_event();
        t_ramp_event ev;
        int          roll;
        int          span;
        int          aim;
        ev.target = larc_pkg::POSITION_BITS'($urandom);
        ev.busy   = ($urandom_range(99) < 20);
        ev.link   = ($urandom_range(99) < 4);
        roll      = $urandom_range(99);
        if (positioner.kind != larc_pkg::KIND_NONE) begin
            ev.mode = (roll < 6) ? larc_pkg::t_mode'($urandom_range(2)) : larc_pkg::MODE_TICK;
        end else if (roll < 30) begin
            ev.mode = larc_pkg::MODE_SET;
            if ($urandom_range(99) < 70) begin
                span = (positioner.step_size == 0) ? 1 : int'(positioner.step_size);
                aim  = int'(positioner.committed) + int'($urandom_range(6 * span)) - 3 * span;
                if (aim < 0) aim = 0;
                if (aim > POS_TOP) aim = POS_TOP;
                ev.target = larc_pkg::POSITION_BITS'(aim);
            end
        end else if (roll < 50) begin
            ev.mode = larc_pkg::MODE_UP;
        end else if (roll < 70) begin
            ev.mode = larc_pkg::MODE_DOWN;
        end else begin
            ev.mode = larc_pkg::MODE_TICK;
        end
        return ev;
    endfunction

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_event(t_ramp_event ev);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_mode            <= ev.mode;
        i_target_position <= ev.target;
        i_actuator_busy   <= ev.busy;
        i_link_error      <= ev.link;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        positioner.note_event(ev);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (positioner.owed_beats.size() != 0);
    endtask

    task automatic write_reg(logic [larc_pkg::CFG_INDEX_BITS-1:0] idx, int data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= larc_pkg::CFG_DATA_BITS'(data);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        positioner.write_reg(idx, larc_pkg::CFG_DATA_BITS'(data));
        @(negedge i_clk);
    endtask

    task automatic configure(int step, int idle, int retry, int start);
        wait_drained();
        write_reg(larc_pkg::CFG_RAMP_STEP, step);
        write_reg(larc_pkg::CFG_IDLE_POS, idle);
        write_reg(larc_pkg::CFG_RETRY_LIMIT, retry);
        write_reg(larc_pkg::CFG_START_POS, start);
    endtask

    // one event, then clean ticks until any ramp it started has ended
    task automatic send_settled(larc_pkg::t_mode m);
        send_event(make_event(m, 0, 1'b0, 1'b0));
        while (positioner.kind != larc_pkg::KIND_NONE) begin
            send_event(make_event(larc_pkg::MODE_TICK, 0, 1'b0, 1'b0));
        end
    endtask

    task automatic run_random(int count);
        repeat (count) begin
            if ($urandom_range(99) < 2) wait_drained();
            send_event(pick_event());
        end
    endtask

    initial begin
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_index       = '0;
        i_cfg_data        = '0;
        i_in_valid        = 1'b0;
        i_mode            = larc_pkg::MODE_TICK;
        i_target_position = '0;
        i_actuator_busy   = 1'b0;
        i_link_error      = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: one-step ramps, abort on the second busy poll
        configure(POS_TOP, 512, 2, POS_TOP);
        send_event(make_event(larc_pkg::MODE_DOWN, 0, 1'b0, 1'b0));        // unmatched
        send_event(make_event(larc_pkg::MODE_TICK, 0, 1'b1, 1'b1));        // tick, no ramp
        send_event(make_event(larc_pkg::MODE_SET, POS_TOP, 1'b1, 1'b1));
        send_event(make_event(larc_pkg::MODE_SET, 0, 1'b0, 1'b0));
        send_event(make_event(larc_pkg::MODE_UP, POS_TOP, 1'b1, 1'b1));    // wake
        send_event(make_event(larc_pkg::MODE_SET, 100, 1'b0, 1'b0));      // rejected
        send_event(make_event(larc_pkg::MODE_TICK, 0, 1'b1, 1'b0));
        send_event(make_event(larc_pkg::MODE_TICK, 0, 1'b0, 1'b0));
        send_event(make_event(larc_pkg::MODE_UP, 0, 1'b0, 1'b0));
        send_event(make_event(larc_pkg::MODE_DOWN, 0, 1'b0, 1'b0));
        send_event(make_event(larc_pkg::MODE_SET, POS_TOP, 1'b0, 1'b0));  // move
        send_event(make_event(larc_pkg::MODE_TICK, 0, 1'b1, 1'b1));        // link abort
        send_event(make_event(larc_pkg::MODE_SET, 0, 1'b0, 1'b0));        // move to same spot
        send_event(make_event(larc_pkg::MODE_TICK, 0, 1'b0, 1'b0));
        send_event(make_event(larc_pkg::MODE_SET, 700, 1'b0, 1'b0));
        send_event(make_event(larc_pkg::MODE_TICK, 0, 1'b1, 1'b0));
        send_event(make_event(larc_pkg::MODE_TICK, 0, 1'b1, 1'b0));        // busy abort
        send_event(make_event(larc_pkg::MODE_DOWN, 0, 1'b0, 1'b0));        // sleep
        send_event(make_event(larc_pkg::MODE_TICK, 0, 1'b0, 1'b1));        // sleep aborted
        send_event(make_event(larc_pkg::MODE_UP, 0, 1'b0, 1'b0));
        send_event(make_event(larc_pkg::MODE_TICK, 0, 1'b1, 1'b1));        // wake aborted
        send_event(make_event(larc_pkg::MODE_UP, 0, 1'b0, 1'b0));
        send_event(make_event(larc_pkg::MODE_TICK, 0, 1'b0, 1'b0));
        send_event(make_event(larc_pkg::MODE_DOWN, 0, 1'b0, 1'b0));
        send_event(make_event(larc_pkg::MODE_TICK, 0, 1'b0, 1'b0));        // standby
        run_random(RANDOM_PER_PHASE);

        send_idle_pct  = 46;
        recv_stall_pct = 18;
        configure(1, 0, 1, 0);
        run_random(RANDOM_PER_PHASE);

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        configure($urandom_range(200, 2), POS_TOP, 255, $urandom_range(POS_TOP));
        run_random(RANDOM_PER_PHASE);

        // user count saturation
        repeat (int'(larc_pkg::USERS_MAX) + 2) send_settled(larc_pkg::MODE_UP);
        repeat (2) send_settled(larc_pkg::MODE_DOWN);

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (positioner.mismatches == 0 && positioner.owed_beats.size() == 0) begin
            $display("[lens_actuator_ramp_controller_core] OK");
        end else begin
            $display("[lens_actuator_ramp_controller_core] ERROR");
        end
        $finish;
    end
endmodule

[files.f]
+incdir+design
design/larc_pkg.sv
design/lens_actuator_ramp_controller_core.sv
dv/lens_actuator_ramp_controller_core_tb.sv
